// ----- design/json_leveled_structural_index_top_defines.svh -----
// Assertion macros for the structural index block
`ifndef JSON_LEVELED_STRUCTURAL_INDEX_TOP_DEFINES_SVH
`define JSON_LEVELED_STRUCTURAL_INDEX_TOP_DEFINES_SVH
`ifndef SYNTH
`define JLSI_ASSERT(lbl, en, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cond)) \
    else $error("jlsi check failed");
`define JLSI_ASSERT_NXT(lbl, en, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cond)) \
    else $error("jlsi check failed");
`else
`define JLSI_ASSERT(lbl, en, cond)
`define JLSI_ASSERT_NXT(lbl, en, cond)
`endif
`endif

// ----- design/jlsi_pkg.sv -----
package jlsi_pkg;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [63:0] EVEN_MASK = 64'h5555555555555555;
  localparam logic signed [11:0] NEST_MAX = 12'sd2047;
  localparam logic signed [11:0] NEST_MIN = -12'sd2048;

  typedef struct packed {
    logic        rec_start;
    logic [63:0] colon;
    logic [63:0] comma;
    logic [63:0] lb;
    logic [63:0] rb;
    logic [63:0] quotes;
  } bitmaps_t;

  function automatic logic [63:0] match_byte(input logic [511:0] d, input logic [7:0] c);
    logic [63:0] m;
    for (int k = 0; k < 64; k++) begin
      m[k] = (d[k*8 +: 8] == c);
    end
    return m;
  endfunction

  function automatic logic [63:0] prefix_xor(input logic [63:0] x);
    logic [63:0] y;
    y = x;
    y = y ^ (y << 1);
    y = y ^ (y << 2);
    y = y ^ (y << 4);
    y = y ^ (y << 8);
    y = y ^ (y << 16);
    y = y ^ (y << 32);
    return y;
  endfunction
endpackage

// ----- design/json_leveled_structural_index_top.sv -----
// Pipeline: a request passes 3 classify stages, the walk load, one step per unquoted
//   bracket (0..64) plus a tail step, and the hand-off to the output register.
// Throughput: the walk shares one 64-bit subtract unit, results leave one level per
//   cycle while the receiver is ready, and input waits until the last result of a
//   block is taken.
// Reset (rst_n low, synchronous) clears carries, nesting level to -1, block count,
//   and sets level_count to 16.
module json_leveled_structural_index_top #(
  parameter int MAX_LEVELS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [511:0] in_tdata,   // chunk_0 .. chunk_7, 64 bits each
  input  logic         in_tuser,   // record_start
  output logic         out_tvalid,
  input  logic         out_tready,
  // level[3:0], colon map, comma map, quote map, block_index[19:0],
  // deepest_level[11:0], 4 zero pad bits
  output logic [231:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_wen,
  input  logic [4:0]   cfg_wdata    // level_count
);
  import jlsi_pkg::*;

  localparam int NLEV = (MAX_LEVELS < 16) ? MAX_LEVELS : 16;
  localparam int LW   = (NLEV > 1) ? $clog2(NLEV) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]   state_r;
  logic [4:0]   lvl_cnt_r;
  logic [19:0]  blk_cnt_r, blk_idx_r;
  logic [3:0]   k_r, top_lvl;
  logic [63:0]  quotes_r;
  logic         ov_r, last_r;
  logic [227:0] od_r;

  logic         accept, maps_vld, walk_done;
  bitmaps_t     maps;
  logic [63:0]  colon_rd, comma_rd;
  logic [11:0]  deepest;

  // effective top level: 0 acts as 1, large values clip to storage depth
  always_comb begin
    if (lvl_cnt_r == 5'd0) begin
      top_lvl = 4'd0;
    end else if (lvl_cnt_r > 5'(NLEV)) begin
      top_lvl = 4'(NLEV - 1);
    end else begin
      top_lvl = 4'(lvl_cnt_r - 5'd1);
    end
  end

  assign accept = in_tvalid && in_tready;

  jlsi_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept),
    .data      (in_tdata),
    .rec_start (in_tuser),
    .maps_vld  (maps_vld),
    .maps      (maps)
  );

  jlsi_walk #(.NLEV(NLEV), .LW(LW)) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (maps_vld),
    .maps     (maps),
    .top      (top_lvl),
    .rd_idx   (k_r[LW-1:0]),
    .done     (walk_done),
    .colon_rd (colon_rd),
    .comma_rd (comma_rd),
    .deepest  (deepest)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lvl_cnt_r <= 5'd16;
      blk_cnt_r <= 20'd0;
      k_r       <= 4'd0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        lvl_cnt_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            blk_cnt_r <= (in_tuser ? 20'd0 : blk_cnt_r) + 20'd1;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (maps_vld) begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            k_r     <= 4'd0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // one level per request; the next loads as the previous is taken
          if (!ov_r || out_tready) begin
            ov_r <= 1'b1;
            if (k_r == top_lvl) begin
              state_r <= S_DRAIN;
            end else begin
              k_r <= k_r + 4'd1;
            end
          end
        end
        S_DRAIN: begin
          if (out_tready) begin
            ov_r    <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_idx_r <= in_tuser ? 20'd0 : blk_cnt_r;
    end
    if (maps_vld) begin
      quotes_r <= maps.quotes;
    end
    if (state_r == S_EMIT && (!ov_r || out_tready)) begin
      od_r   <= {deepest, blk_idx_r, quotes_r, comma_rd, colon_rd, k_r};
      last_r <= (k_r == top_lvl);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, od_r};
  assign out_tlast  = last_r;

`include "json_leveled_structural_index_top_defines.svh"

  `JLSI_ASSERT(a_idle_no_result, in_tready, !out_tvalid)
  `JLSI_ASSERT(a_last_is_top, out_tvalid && out_tlast, out_tdata[3:0] == top_lvl)
  `JLSI_ASSERT_NXT(a_busy_after_req, accept, !in_tready)
endmodule

// ----- design/jlsi_scan.sv -----
module jlsi_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [511:0]       data,
  input  logic               rec_start,
  output logic               maps_vld,
  output jlsi_pkg::bitmaps_t maps
);
  import jlsi_pkg::*;

  // stage A: raw byte classes
  logic        vld_a_r, rs_a_r;
  logic [63:0] colon_a_r, comma_a_r, quote_a_r, bs_a_r, lb_a_r, rb_a_r;
  // stage B: escape resolution
  logic        vld_b_r, rs_b_r, obc_r, obc_nxt;
  logic [63:0] colon_b_r, comma_b_r, lb_b_r, rb_b_r, quotes_b_r, quotes_nxt;
  // stage C: string mask
  logic        vld_c_r, instr_r, instr_nxt;
  bitmaps_t    maps_r, maps_nxt;

  logic        prev;
  logic [63:0] bs_head, esm, ev_head, od_head, ev_sum, esc_pos;
  logic [64:0] odd_sum;
  logic [63:0] od_run, smask, keep;

  always_comb begin
    prev     = rs_a_r ? 1'b0 : obc_r;
    bs_head  = bs_a_r & ~(bs_a_r << 1);
    esm      = EVEN_MASK ^ {63'd0, prev};
    ev_head  = bs_head & esm;
    od_head  = bs_head & ~esm;
    ev_sum   = bs_a_r + ev_head;
    odd_sum  = {1'b0, bs_a_r} + {1'b0, od_head};
    obc_nxt  = odd_sum[64];
    od_run   = odd_sum[63:0] | {63'd0, prev};
    esc_pos  = ((ev_sum & ~bs_a_r) & ~EVEN_MASK) |
               ((od_run & ~bs_a_r) & EVEN_MASK);
    quotes_nxt = quote_a_r & ~esc_pos;
  end

  always_comb begin
    smask = prefix_xor(quotes_b_r);
    if (!rs_b_r && instr_r) begin
      smask = ~smask;
    end
    instr_nxt          = smask[63];
    keep               = ~smask;
    maps_nxt.rec_start = rs_b_r;
    maps_nxt.colon     = colon_b_r & keep;
    maps_nxt.comma     = comma_b_r & keep;
    maps_nxt.lb        = lb_b_r & keep;
    maps_nxt.rb        = rb_b_r & keep;
    maps_nxt.quotes    = quotes_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      obc_r   <= 1'b0;
      instr_r <= 1'b0;
    end else begin
      vld_a_r <= go;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      if (vld_a_r) begin
        obc_r <= obc_nxt;
      end
      if (vld_b_r) begin
        instr_r <= instr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rs_a_r    <= rec_start;
      colon_a_r <= match_byte(data, CH_COLON);
      comma_a_r <= match_byte(data, CH_COMMA);
      quote_a_r <= match_byte(data, CH_QUOTE);
      bs_a_r    <= match_byte(data, CH_BSLASH);
      lb_a_r    <= match_byte(data, CH_LBRACE) | match_byte(data, CH_LBRACK);
      rb_a_r    <= match_byte(data, CH_RBRACE) | match_byte(data, CH_RBRACK);
    end
    if (vld_a_r) begin
      rs_b_r     <= rs_a_r;
      colon_b_r  <= colon_a_r;
      comma_b_r  <= comma_a_r;
      lb_b_r     <= lb_a_r;
      rb_b_r     <= rb_a_r;
      quotes_b_r <= quotes_nxt;
    end
    if (vld_b_r) begin
      maps_r <= maps_nxt;
    end
  end

  assign maps_vld = vld_c_r;
  assign maps     = maps_r;
endmodule

// ----- design/jlsi_walk.sv -----
module jlsi_walk #(
  parameter int NLEV = 16,
  parameter int LW   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  jlsi_pkg::bitmaps_t maps,
  input  logic [3:0]         top,
  input  logic [LW-1:0]      rd_idx,
  output logic               done,
  output logic [63:0]        colon_rd,
  output logic [63:0]        comma_rd,
  output logic [11:0]        deepest
);
  import jlsi_pkg::*;

  logic               run_r, done_r;
  logic [63:0]        cb_r, first_r, colon_r, comma_r, lb_r;
  logic signed [11:0] lvl_r, deep_r, lvl_nxt, deep_nxt;
  logic [63:0]        colon_acc_r [NLEV];
  logic [63:0]        comma_acc_r [NLEV];

  logic               cb_zero, use_colon, is_open;
  logic [63:0]        bit_lo, second, mask, seg_colon, seg_comma;
  logic signed [12:0] lvl_p1;

  // one bracket per cycle through the shared subtractor
  always_comb begin
    cb_zero   = (cb_r == 64'd0);
    bit_lo    = cb_r & (~cb_r + 64'd1);
    second    = cb_zero ? 64'h8000000000000000 : bit_lo;
    mask      = (second - first_r) | (cb_zero ? second : 64'd0);
    seg_colon = mask & colon_r;
    seg_comma = mask & comma_r;
    use_colon = (seg_colon != 64'd0);
    is_open   = (bit_lo & lb_r) != 64'd0;
    lvl_p1    = {lvl_r[11], lvl_r} + 13'sd1;
    if (is_open) begin
      lvl_nxt = (lvl_r == NEST_MAX) ? lvl_r : lvl_r + 12'sd1;
    end else begin
      lvl_nxt = (lvl_r == NEST_MIN) ? lvl_r : lvl_r - 12'sd1;
    end
    deep_nxt = (lvl_nxt > deep_r) ? lvl_nxt : deep_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      lvl_r  <= -12'sd1;
      deep_r <= -12'sd1;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        if (maps.rec_start) begin
          lvl_r  <= -12'sd1;
          deep_r <= -12'sd1;
        end
      end else if (run_r) begin
        if (cb_zero) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          lvl_r  <= lvl_nxt;
          deep_r <= deep_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cb_r    <= maps.lb | maps.rb;
      first_r <= 64'd1;
      colon_r <= maps.colon;
      comma_r <= maps.comma;
      lb_r    <= maps.lb;
    end else if (run_r && !cb_zero) begin
      cb_r    <= cb_r & ~bit_lo;
      first_r <= second;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLEV; i++) begin
      if (start) begin
        colon_acc_r[i] <= 64'd0;
        comma_acc_r[i] <= 64'd0;
      end else if (run_r && (5'(i) <= {1'b0, top})) begin
        if (lvl_r == 12'(i)) begin
          if (use_colon) begin
            colon_acc_r[i] <= colon_acc_r[i] | seg_colon |
                              ((!cb_zero && !is_open) ? bit_lo : 64'd0);
            comma_acc_r[i] <= comma_acc_r[i] |
                              ((!cb_zero && !is_open) ? bit_lo : 64'd0);
          end else begin
            colon_acc_r[i] <= colon_acc_r[i] |
                              ((!cb_zero && !is_open) ? bit_lo : 64'd0);
            comma_acc_r[i] <= comma_acc_r[i] | seg_comma |
                              ((!cb_zero && !is_open) ? bit_lo : 64'd0);
          end
        end else if (!cb_zero && is_open && lvl_p1 == 13'(i)) begin
          comma_acc_r[i] <= comma_acc_r[i] | bit_lo;
        end
      end
    end
  end

  assign done     = done_r;
  assign colon_rd = colon_acc_r[rd_idx];
  assign comma_rd = comma_acc_r[rd_idx];
  assign deepest  = deep_r;
endmodule

// ----- sim/tb_json_leveled_structural_index_top.sv -----
`timescale 1ns / 100ps

// Block-level bench for the leveled JSON structural indexer.
// Requests are 64-byte text blocks; every accepted block is run through a local
// model of the index, which queues one expected result per level in use.
// The output monitor pops those and compares field by field.
module tb_json_leveled_structural_index_top;
  import jlsi_pkg::*;

  localparam int LVLS      = 16;
  localparam int DRAIN_CYC = 120;    // classify + 65 walk steps + 16 levels, rounded up
  localparam int STALL_LIM = 20000;  // cycles with no handshake on either side
  localparam int HOLD_CYC  = 400;    // long receiver hold-off

  // one expected or observed result
  typedef struct packed {
    logic [3:0]  level;
    logic [63:0] colon;
    logic [63:0] comma;
    logic [63:0] quote;
    logic [19:0] blk;
    logic [11:0] deep;
    logic        last;
  } lvl_res_t;

  // directed stimulus row; zero_maps marks rows whose results are known by eye
  typedef struct {
    string text;
    bit    start;
    bit    zero_maps;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [511:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [231:0] out_tdata;
  logic         out_tlast;
  logic         cfg_wen = 1'b0;
  logic [4:0]   cfg_wdata = 5'd16;

  json_leveled_structural_index_top #(.MAX_LEVELS(LVLS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Index model state: escape/string carries, nesting, block count, level count
  // ---------------------------------------------------------------------------
  logic        esc_carry;
  logic        in_str;
  int          nest;
  int          deepest;
  logic [19:0] blk_cnt;
  logic [4:0]  lvl_count;
  lvl_res_t    level_q[$];   // expected per-level results, oldest first

  int errors     = 0;
  int n_blocks   = 0;
  int n_results  = 0;
  int send_idle  = 0;        // percent of cycles the sender stays quiet
  int recv_idle  = 0;        // percent of cycles the receiver stalls
  logic hold_rx  = 1'b0;
  int quiet_cyc  = 0;

  function automatic logic [63:0] find_char(logic [511:0] d, logic [7:0] c);
    logic [63:0] m;
    for (int k = 0; k < 64; k++) m[k] = (d[k*8 +: 8] == c);
    return m;
  endfunction

  function automatic logic [63:0] running_xor(logic [63:0] x);
    for (int s = 1; s < 64; s = s * 2) x = x ^ (x << s);
    return x;
  endfunction

  // Index one accepted block and queue its results.
  function automatic void index_block(logic [511:0] d, logic start);
    logic [63:0] colon, comma, lb, rb, cb, bs, quotes, smask, keep;
    logic [63:0] edges, esm, ev_st, od_st, ev_c, od_c, odd_end, prev;
    logic [63:0] first, second, lead, span;
    logic [63:0] col_acc[LVLS];
    logic [63:0] com_acc[LVLS];
    int top, lvl;
    lvl_res_t r;

    top = (lvl_count < 1) ? 0 : (lvl_count > LVLS) ? LVLS - 1 : lvl_count - 1;
    if (start) begin
      esc_carry = 1'b0; in_str = 1'b0; nest = -1; deepest = -1; blk_cnt = '0;
    end
    prev = {63'd0, esc_carry};
    for (int i = 0; i < LVLS; i++) begin
      col_acc[i] = '0; com_acc[i] = '0;
    end

    colon = find_char(d, CH_COLON);
    comma = find_char(d, CH_COMMA);
    bs    = find_char(d, CH_BSLASH);
    lb    = find_char(d, CH_LBRACE) | find_char(d, CH_LBRACK);
    rb    = find_char(d, CH_RBRACE) | find_char(d, CH_RBRACK);

    // odd backslash runs escape the byte after them
    edges = bs & ~(bs << 1);
    esm   = EVEN_MASK ^ prev;
    ev_st = edges & esm;
    od_st = edges & ~esm;
    ev_c  = bs + ev_st;
    od_c  = bs + od_st;
    esc_carry = (od_c < bs);
    od_c  = od_c | prev;
    odd_end = ((ev_c & ~bs) & ~EVEN_MASK) | ((od_c & ~bs) & EVEN_MASK);
    quotes = find_char(d, CH_QUOTE) & ~odd_end;

    smask = running_xor(quotes);
    if (in_str) smask = ~smask;
    in_str = smask[63];
    keep  = ~smask;
    colon &= keep;
    comma &= keep;
    lb &= keep;
    rb &= keep;
    cb = lb | rb;

    lvl = nest;
    if (cb == 0) begin
      if (lvl >= 0 && lvl <= top) begin
        if (colon != 0) col_acc[lvl] |= colon;
        else com_acc[lvl] |= comma;
      end
    end else begin
      first = 64'd1;
      while (first != 0) begin
        lead   = cb & (-cb);
        second = (cb != 0) ? lead : 64'h8000_0000_0000_0000;
        span   = second - first;
        if (cb == 0) span |= second;
        // segment rule: colons win over commas
        if (lvl >= 0 && lvl <= top) begin
          if ((span & colon) != 0) col_acc[lvl] |= span & colon;
          else com_acc[lvl] |= span & comma;
        end
        if (cb == 0) begin
          first = 0;
        end else begin
          if ((lead & lb) != 0) begin
            if (lvl >= 0 && lvl + 1 <= top) com_acc[lvl+1] |= lead;
            if (lvl < 2047) lvl++;
            if (lvl == 0) com_acc[0] |= lead;
          end else begin
            if (lvl >= 0 && lvl <= top) begin
              col_acc[lvl] |= lead;
              com_acc[lvl] |= lead;
            end
            if (lvl > -2048) lvl--;
          end
          if (lvl > deepest) deepest = lvl;
          first = second;
          cb &= cb - 1;
        end
      end
    end
    nest = lvl;

    for (int k = 0; k <= top; k++) begin
      r.level = k[3:0];
      r.colon = col_acc[k];
      r.comma = com_acc[k];
      r.quote = quotes;
      r.blk   = blk_cnt;
      r.deep  = deepest[11:0];
      r.last  = (k == top);
      level_q.push_back(r);
    end
    blk_cnt = blk_cnt + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [511:0] text_block(string s);
    logic [511:0] d;
    for (int i = 0; i < 64; i++) d[i*8 +: 8] = (i < s.len()) ? s[i] : " ";
    return d;
  endfunction

  function automatic logic [511:0] fill_block(logic [7:0] c);
    return {64{c}};
  endfunction

  // Mostly JSON-flavored bytes so that strings, escapes and nesting all get hit.
  function automatic logic [511:0] json_block();
    logic [511:0] d;
    logic [7:0] alpha[12];
    alpha = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_QUOTE, CH_COLON,
              CH_COMMA, CH_BSLASH, "a", "1", " ", CH_QUOTE};
    for (int i = 0; i < 64; i++) begin
      if ($urandom_range(3) == 0) d[i*8 +: 8] = alpha[$urandom_range(11)];
      else d[i*8 +: 8] = ($urandom_range(1) == 0) ? "x" : " ";
    end
    return d;
  endfunction

  function automatic logic [511:0] noise_block();
    logic [511:0] d;
    for (int i = 0; i < 16; i++) d[i*32 +: 32] = $urandom;
    return d;
  endfunction

  // Offer one request and hold it until the handshake; quiet cycles after it
  // at the sender's idle rate.
  task automatic push_block(logic [511:0] d, logic start);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    index_block(d, start);
    n_blocks++;
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  // Register write, only with the block drained.
  task automatic set_levels(logic [4:0] v);
    in_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    lvl_count = v;
  endtask

  task automatic random_blocks(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) push_block(json_block(), $urandom_range(7) == 0);
      else push_block(noise_block(), 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus a long hold when asked
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= !hold_rx && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    lvl_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.level = out_tdata[3:0];
      got.colon = out_tdata[67:4];
      got.comma = out_tdata[131:68];
      got.quote = out_tdata[195:132];
      got.blk   = out_tdata[215:196];
      got.deep  = out_tdata[227:216];
      got.last  = out_tlast;
      n_results++;
      if (level_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: level %0d blk %0d", got.level, got.blk);
      end else begin
        want = level_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch blk %0d level %0d", want.blk, want.level);
            $display("  exp colon %h comma %h quote %h blk %0d deep %h last %b",
                     want.colon, want.comma, want.quote, want.blk, want.deep, want.last);
            $display("  got colon %h comma %h quote %h blk %0d deep %h last %b",
                     got.colon, got.comma, got.quote, got.blk, got.deep, got.last);
          end
        end
      end
    end
  end

  // Watchdog: any handshake resets the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= STALL_LIM) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               STALL_LIM, level_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t rows[$];
    lvl_res_t chk;
    logic [511:0] esc_blk;

    // Directed rows: blank, simple object, escapes and strings spanning blocks,
    // a backslash at the block's last byte, saturating-free deep/negative runs,
    // all-ones and all-zero bytes.
    rows.push_back('{"", 1'b1, 1'b1});
    rows.push_back('{"{\"a\":1,\"b\":[1,2,{\"c\":3}],\"d\":\"x,y:z\"}", 1'b1, 1'b0});
    rows.push_back('{"[1,2,3] , {\"k\":[]} : ,", 1'b1, 1'b0});
    rows.push_back('{"{\"e\":\"q \\\" in , : [x] {y}", 1'b1, 1'b0});
    rows.push_back('{" tail\" , \"n\": 5 }", 1'b0, 1'b0});
    rows.push_back('{"{\"s\":\"\\\\\" , \"t\":\"\\\\\\\"\" }", 1'b1, 1'b0});
    rows.push_back('{"[\"abc", 1'b1, 1'b0});
    rows.push_back('{"still, in: string {[ \" ] , 1 ]", 1'b0, 1'b0});
    rows.push_back('{"}]}] , : ,", 1'b1, 1'b0});
    rows.push_back('{"{a:1,b:2}[c,d]{e:[f,{g:h}]}", 1'b0, 1'b0});
    rows.push_back('{",,,,,:::::", 1'b1, 1'b0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    esc_carry = 1'b0; in_str = 1'b0; nest = -1; deepest = -1; blk_cnt = '0;
    lvl_count = 5'd16;
    @(posedge clk);

    // phase 0: directed, full level count, no idling
    set_levels(5'd16);
    foreach (rows[i]) begin
      push_block(text_block(rows[i].text), rows[i].start);
      if (rows[i].zero_maps) begin
        // blank block right after a record start: empty maps, no nesting yet
        chk = level_q[level_q.size() - 1];
        if (chk.colon != 0 || chk.comma != 0 || chk.quote != 0 || chk.deep != 12'hfff) begin
          errors++;
          $display("blank block: unexpected maps or depth %h", chk.deep);
        end
      end
    end
    // backslash on the last byte escapes the first byte of the next block
    esc_blk = text_block("\"s\": \"ab");
    esc_blk[511:504] = CH_BSLASH;
    push_block(esc_blk, 1'b1);
    push_block(text_block("\" , x \"], 1"), 1'b0);
    push_block(fill_block(CH_LBRACE), 1'b1);
    push_block(fill_block(CH_RBRACK), 1'b0);
    push_block(fill_block(CH_RBRACE), 1'b0);
    push_block(fill_block(8'hff), 1'b1);
    push_block(fill_block(8'h00), 1'b0);

    // phase 1: one level, sender quiet 25%, receiver stalls 51%
    set_levels(5'd1);
    send_idle = 25; recv_idle = 51;
    random_blocks(60);

    // phase 2: zero acts as one; swapped idling, plus a long receiver hold
    set_levels(5'd0);
    send_idle = 51; recv_idle = 25;
    fork
      begin
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    send_idle = 0;
    random_blocks(20);
    send_idle = 51;
    random_blocks(40);

    // phase 3: out-of-range count clamps to the maximum; no idling;
    // drive nesting into both saturation limits
    set_levels(5'd31);
    send_idle = 0; recv_idle = 0;
    push_block(fill_block(CH_LBRACK), 1'b1);
    for (int i = 0; i < 33; i++) push_block(fill_block(CH_LBRACE), 1'b0);
    for (int i = 0; i < 66; i++) push_block(fill_block(CH_RBRACE), 1'b0);
    random_blocks(30);

    // phase 4: a mid-range count
    set_levels(5'($urandom_range(2, 15)));
    random_blocks(60);

    in_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d blocks, %0d level results, level counts 16/1/0/31/mid,",
             n_blocks, n_results);
    $display("escapes and strings across blocks, nesting saturation, long output stall");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
